>>> src/iir2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir2_pkg
// Shared constants and register indexes of the second-order IIR low-pass.
// ----------------------------------------------------------------------------
package iir2_pkg;

    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_IN_NOW  = 8'd0,
        REG_COEF_IN_PREV = 8'd1,
        REG_COEF_FB_ONE  = 8'd2,
        REG_COEF_FB_TWO  = 8'd3
    } t_reg_idx;

    localparam int NUM_COEFS = 4;

endpackage

>>> src/iir2_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir2_if
// Valid/ready channels: input sample, filtered result and coefficient write.
// ----------------------------------------------------------------------------
interface iir2_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir2_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface iir2_cfg_if #(
    parameter int COEF_WIDTH = 18
);
    logic                              valid;
    logic                              ready;
    logic [iir2_pkg::CFG_IDX_W-1:0]    index;
    logic [COEF_WIDTH-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/iir2_coef_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir2_coef_regs
// Coefficient register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module iir2_coef_regs #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    iir2_cfg_if.sink                            i_cfg,
    output logic [iir2_pkg::NUM_COEFS-1:0][COEF_FRAC_BITS+1:0] o_coefs
);

    localparam int COEF_WIDTH = COEF_FRAC_BITS + 2;

    logic [iir2_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] r_coefs;

    assign i_cfg.ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs[0] <= {2'b01, {COEF_FRAC_BITS{1'b0}}};
            r_coefs[1] <= '0;
            r_coefs[2] <= '0;
            r_coefs[3] <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                iir2_pkg::REG_COEF_IN_NOW:  r_coefs[0] <= i_cfg.data;
                iir2_pkg::REG_COEF_IN_PREV: r_coefs[1] <= i_cfg.data;
                iir2_pkg::REG_COEF_FB_ONE:  r_coefs[2] <= i_cfg.data;
                iir2_pkg::REG_COEF_FB_TWO:  r_coefs[3] <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/iir2_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir2_mac
// Four products, full-width sum, round half up, saturate to the sample range.
// ----------------------------------------------------------------------------
module iir2_mac #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic signed [SAMPLE_WIDTH-1:0]                         i_u,
    input  logic signed [SAMPLE_WIDTH-1:0]                         i_u_prev,
    input  logic signed [SAMPLE_WIDTH-1:0]                         i_y_prev,
    input  logic signed [SAMPLE_WIDTH-1:0]                         i_y_prev_two,
    input  logic [iir2_pkg::NUM_COEFS-1:0][COEF_FRAC_BITS+1:0]     i_coefs,
    output logic signed [SAMPLE_WIDTH-1:0]                         o_y,
    output logic                                                   o_clip
);

    localparam int CW    = COEF_FRAC_BITS + 2;
    localparam int PW    = SAMPLE_WIDTH + CW;
    localparam int ACC_W = PW + 2;
    localparam int SH_W  = ACC_W - COEF_FRAC_BITS;

    localparam logic [ACC_W-1:0] RND =
        {{(ACC_W - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};

    logic signed [CW-1:0]    c0, c1, c2, c3;
    logic signed [PW-1:0]    p0, p1, p2, p3;
    logic signed [ACC_W-1:0] acc;
    logic [SH_W-1:0]         sh;
    logic [SH_W-SAMPLE_WIDTH:0] hi;

    assign c0 = $signed(i_coefs[0]);
    assign c1 = $signed(i_coefs[1]);
    assign c2 = $signed(i_coefs[2]);
    assign c3 = $signed(i_coefs[3]);

    assign p0 = PW'(c0) * PW'(i_u);
    assign p1 = PW'(c1) * PW'(i_u_prev);
    assign p2 = PW'(c2) * PW'(i_y_prev);
    assign p3 = PW'(c3) * PW'(i_y_prev_two);

    assign acc = $signed({{2{p0[PW-1]}}, p0}) + $signed({{2{p1[PW-1]}}, p1})
               - $signed({{2{p2[PW-1]}}, p2}) - $signed({{2{p3[PW-1]}}, p3})
               + $signed(RND);

    // floor by dropping the fraction bits
    assign sh     = acc[ACC_W-1:COEF_FRAC_BITS];
    assign hi     = sh[SH_W-1:SAMPLE_WIDTH-1];
    assign o_clip = !((&hi) || (~|hi));

    always_comb begin
        if (!o_clip) begin
            o_y = $signed(sh[SAMPLE_WIDTH-1:0]);
        end else if (sh[SH_W-1]) begin
            o_y = $signed({1'b1, {(SAMPLE_WIDTH - 1){1'b0}}});
        end else begin
            o_y = $signed({1'b0, {(SAMPLE_WIDTH - 1){1'b1}}});
        end
    end

endmodule

>>> src/second_order_iir_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_iir_lowpass
// Second-order IIR low-pass: input register, one multiply-accumulate pass,
// result register; saturated output fed back as filter state.
// ----------------------------------------------------------------------------
// An accepted sample is held in the input register, its result in the result
// register. Throughput: one sample per cycle while the output is not stalled;
// the four products and the sum run in the single pass between both registers.
// Reset: synchronous, active low; clears the filter history and the valid
// flags and sets coefficient 0 to 1.0, the others to 0.
module second_order_iir_lowpass #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iir2_in_if.sink    i_in,
    iir2_cfg_if.sink   i_cfg,
    iir2_out_if.source o_res
);

    logic [iir2_pkg::NUM_COEFS-1:0][COEF_FRAC_BITS+1:0] coefs;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_clip;
    logic signed [SAMPLE_WIDTH-1:0] r_u_prev;
    logic signed [SAMPLE_WIDTH-1:0] r_y_prev;
    logic signed [SAMPLE_WIDTH-1:0] r_y_prev_two;

    logic                           advance;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic                           clip;

    iir2_coef_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_coefs (coefs)
    );

    iir2_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_u          (r_in_sample),
        .i_u_prev     (r_u_prev),
        .i_y_prev     (r_y_prev),
        .i_y_prev_two (r_y_prev_two),
        .i_coefs      (coefs),
        .o_y          (y),
        .o_clip       (clip)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_res.valid      = r_out_valid;
    assign o_res.sample_out = r_out_sample;
    assign o_res.clipped    = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_u_prev     <= '0;
            r_y_prev     <= '0;
            r_y_prev_two <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_u_prev     <= r_in_sample;
                r_y_prev     <= y;
                r_y_prev_two <= r_y_prev;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_sample <= i_in.sample_in;
        end
        if (advance) begin
            r_out_sample <= y;
            r_out_clip   <= clip;
        end
    end

endmodule
